@@ hw/rtl/ssi_pkg.sv @@
// Shared widths, result codes and stage bundles for the segment intersection core.
package ssi_pkg;

  localparam int FIELD_W  = 16;              // width of one coordinate field
  localparam int N_FIELDS = 8;               // coordinate fields per input transfer
  localparam int COORD_W  = FIELD_W + 1;     // coordinate after extension
  localparam int DIFF_W   = COORD_W;         // deltas and offsets stay within this
  localparam int PROD_W   = 2 * DIFF_W;      // products, determinant, numerators
  localparam int MAG_W    = PROD_W - 1;      // magnitude of determinant or numerator
  localparam int AMAG_W   = DIFF_W - 1;      // magnitude of a delta
  localparam int LO_W     = 17;              // low slice of a numerator magnitude
  localparam int HI_W     = MAG_W - LO_W;    // high slice of a numerator magnitude
  localparam int NUM_W    = AMAG_W + MAG_W;  // dividend magnitude
  localparam int QUOT_W   = 16;              // quotient magnitude on a hit
  localparam int OUT_W    = 16;              // result coordinate width

  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_PARALLEL = 2'd1,
    OUT_OUTSIDE  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic               hit;
    outcome_t           outcome;
    logic               neg_x;
    logic               neg_y;
    logic [OUT_W-1:0]   base_x;
    logic [OUT_W-1:0]   base_y;
  } side_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic [NUM_W-1:0]   num_x;
    logic [NUM_W-1:0]   num_y;
    logic [MAG_W-1:0]   den;
  } div_in_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic [QUOT_W-1:0]  q_x;
    logic [QUOT_W-1:0]  q_y;
  } div_out_t;

endpackage

@@ hw/rtl/ssi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
module ssi_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  ssi_pkg::div_in_t  din,
  output ssi_pkg::div_out_t dout
);

  localparam int QW = ssi_pkg::QUOT_W;
  localparam int NW = ssi_pkg::NUM_W;
  localparam int MW = ssi_pkg::MAG_W;

  logic                 val_r  [QW];
  ssi_pkg::side_t       side_r [QW];
  logic [MW-1:0]        den_r  [QW];
  logic [NW-1:0]        rx_r   [QW];
  logic [NW-1:0]        ry_r   [QW];
  logic [QW-1:0]        qx_r   [QW];
  logic [QW-1:0]        qy_r   [QW];

  logic                 src_v    [QW];
  ssi_pkg::side_t       src_side [QW];
  logic [MW-1:0]        src_den  [QW];
  logic [NW-1:0]        src_rx   [QW];
  logic [NW-1:0]        src_ry   [QW];
  logic [QW-1:0]        src_qx   [QW];
  logic [QW-1:0]        src_qy   [QW];

  logic [NW-1:0]        rx_nxt [QW];
  logic [NW-1:0]        ry_nxt [QW];
  logic [QW-1:0]        qx_nxt [QW];
  logic [QW-1:0]        qy_nxt [QW];

  always_comb begin
    logic [NW-1:0] dsh;
    src_v[0]    = din.valid;
    src_side[0] = din.side;
    src_den[0]  = din.den;
    src_rx[0]   = din.num_x;
    src_ry[0]   = din.num_y;
    src_qx[0]   = '0;
    src_qy[0]   = '0;
    for (int k = 1; k < QW; k++) begin
      src_v[k]    = val_r[k-1];
      src_side[k] = side_r[k-1];
      src_den[k]  = den_r[k-1];
      src_rx[k]   = rx_r[k-1];
      src_ry[k]   = ry_r[k-1];
      src_qx[k]   = qx_r[k-1];
      src_qy[k]   = qy_r[k-1];
    end
    // stage k settles quotient bit QW-1-k against the divisor shifted to match
    for (int k = 0; k < QW; k++) begin
      dsh       = NW'(src_den[k]) << (QW - 1 - k);
      qx_nxt[k] = src_qx[k];
      qy_nxt[k] = src_qy[k];
      if (src_rx[k] >= dsh) begin
        rx_nxt[k]             = src_rx[k] - dsh;
        qx_nxt[k][QW - 1 - k] = 1'b1;
      end else begin
        rx_nxt[k] = src_rx[k];
      end
      if (src_ry[k] >= dsh) begin
        ry_nxt[k]             = src_ry[k] - dsh;
        qy_nxt[k][QW - 1 - k] = 1'b1;
      end else begin
        ry_nxt[k] = src_ry[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) begin
        val_r[k] <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 0; k < QW; k++) begin
        val_r[k] <= src_v[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < QW; k++) begin
        side_r[k] <= src_side[k];
        den_r[k]  <= src_den[k];
        rx_r[k]   <= rx_nxt[k];
        ry_r[k]   <= ry_nxt[k];
        qx_r[k]   <= qx_nxt[k];
        qy_r[k]   <= qy_nxt[k];
      end
    end
  end

  assign dout.valid = val_r[QW-1];
  assign dout.side  = side_r[QW-1];
  assign dout.q_x   = qx_r[QW-1];
  assign dout.q_y   = qy_r[QW-1];

endmodule

@@ hw/rtl/segment_segment_intersection_core.sv @@
// Top level of the 2D segment-segment intersection core.
//
//   channel | direction | tdata                              | tuser
//   --------+-----------+------------------------------------+------------------
//   in_     | slave     | 8 x 16-bit Q8.8 coordinates        | -
//   out_    | master    | cross_x, cross_y (16 bits each)    | hit, outcome[1:0]
//
// One segment pair per cycle while the skid entry is free. A result passes
// six arithmetic stages, sixteen divider stages (one quotient bit each) and
// the output register.
// Reset (rst_n low, synchronous) clears all valid bits and the output buffer.
// A two-entry output buffer holds results while out_tready is low; the
// pipeline freezes only once its spare entry is taken, so nothing is dropped
// or repeated.
module segment_segment_intersection_core #(
  parameter int COORD_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // cross_x, cross_y
  output logic [31:0]  out_tdata,
  // hit, outcome[1:0]
  output logic [2:0]   out_tuser
);

  localparam int FW    = ssi_pkg::FIELD_W;
  localparam int CW    = ssi_pkg::COORD_W;
  localparam int DW    = ssi_pkg::DIFF_W;
  localparam int PW    = ssi_pkg::PROD_W;
  localparam int MW    = ssi_pkg::MAG_W;
  localparam int AW    = ssi_pkg::AMAG_W;
  localparam int LW    = ssi_pkg::LO_W;
  localparam int HW    = ssi_pkg::HI_W;
  localparam int NW    = ssi_pkg::NUM_W;
  localparam int OW    = ssi_pkg::OUT_W;
  localparam int PPW   = AW + LW;
  localparam int EXT_W = (COORD_BITS > FW) ? FW : COORD_BITS;
  localparam int XS    = CW - EXT_W;

  // Coordinates wider than the field read the field as unsigned; otherwise
  // sign-extend the low COORD_BITS bits.
  function automatic logic signed [CW-1:0] coord_of(input logic [FW-1:0] raw);
    logic signed [CW-1:0] t;
    t = signed'({1'b0, raw} << XS);
    if (COORD_BITS > FW) begin
      return signed'({1'b0, raw});
    end
    return t >>> XS;
  endfunction

  function automatic logic signed [PW-1:0] mul_s(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return PW'(a) * PW'(b);
  endfunction

  function automatic logic [PPW-1:0] mul_pp(input logic [AW-1:0] a,
                                            input logic [LW-1:0] b);
    return PPW'(a) * PPW'(b);
  endfunction

  logic adv;

  // ---------------- stage 1: extend coordinates, form deltas ----------------
  logic signed [CW-1:0] crd [ssi_pkg::N_FIELDS];
  logic                 v1_r;
  logic signed [DW-1:0] dax1_r, day1_r, dbx1_r, dby1_r, ox1_r, oy1_r;
  logic [OW-1:0]        bx1_r, by1_r;

  always_comb begin
    for (int k = 0; k < ssi_pkg::N_FIELDS; k++) begin
      crd[k] = coord_of(in_tdata[k*FW +: FW]);
    end
  end

  // ---------------- stage 2: six cross products ----------------
  logic                 v2_r;
  logic signed [PW-1:0] pda2_r, pdb2_r, pnaa2_r, pnab2_r, pnba2_r, pnbb2_r;
  logic signed [DW-1:0] dax2_r, day2_r;
  logic [OW-1:0]        bx2_r, by2_r;

  // ---------------- stage 3: determinant and numerators ----------------
  logic                 v3_r;
  logic signed [PW-1:0] det3_r, na3_r, nb3_r;
  logic signed [DW-1:0] dax3_r, day3_r;
  logic [OW-1:0]        bx3_r, by3_r;

  // ---------------- stage 4: range tests, magnitudes, signs ----------------
  logic                 det_zero, det_pos, in_a, in_b;
  logic signed [PW-1:0] neg_det, neg_na;
  logic signed [DW-1:0] neg_dax, neg_day;
  ssi_pkg::side_t       side4_nxt;
  logic                 v4_r;
  ssi_pkg::side_t       side4_r;
  logic [MW-1:0]        den4_r, namag4_r;
  logic [AW-1:0]        axmag4_r, aymag4_r;

  always_comb begin
    det_zero = (det3_r == '0);
    det_pos  = !det3_r[PW-1] && !det_zero;
    // closed range 0..1 on num/det without dividing
    in_a = det_pos ? (!na3_r[PW-1] && (na3_r <= det3_r))
                   : ((na3_r[PW-1] || (na3_r == '0)) && (na3_r >= det3_r));
    in_b = det_pos ? (!nb3_r[PW-1] && (nb3_r <= det3_r))
                   : ((nb3_r[PW-1] || (nb3_r == '0)) && (nb3_r >= det3_r));
    neg_det = -det3_r;
    neg_na  = -na3_r;
    neg_dax = -dax3_r;
    neg_day = -day3_r;

    side4_nxt.hit = !det_zero && in_a && in_b;
    if (det_zero) begin
      side4_nxt.outcome = ssi_pkg::OUT_PARALLEL;
    end else if (in_a && in_b) begin
      side4_nxt.outcome = ssi_pkg::OUT_HIT;
    end else begin
      side4_nxt.outcome = ssi_pkg::OUT_OUTSIDE;
    end
    side4_nxt.neg_x  = dax3_r[DW-1] ^ na3_r[PW-1] ^ det3_r[PW-1];
    side4_nxt.neg_y  = day3_r[DW-1] ^ na3_r[PW-1] ^ det3_r[PW-1];
    side4_nxt.base_x = bx3_r;
    side4_nxt.base_y = by3_r;
  end

  // ---------------- stage 5: partial products of delta times numerator ------
  logic                 v5_r;
  ssi_pkg::side_t       side5_r;
  logic [MW-1:0]        den5_r;
  logic [PPW-1:0]       ppxl5_r, ppxh5_r, ppyl5_r, ppyh5_r;

  // ---------------- stage 6: combine partial products into dividends --------
  logic                 v6_r;
  ssi_pkg::side_t       side6_r;
  logic [MW-1:0]        den6_r;
  logic [NW-1:0]        numx6_r, numy6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dax1_r   <= crd[2] - crd[0];
      day1_r   <= crd[3] - crd[1];
      dbx1_r   <= crd[6] - crd[4];
      dby1_r   <= crd[7] - crd[5];
      ox1_r    <= crd[0] - crd[4];
      oy1_r    <= crd[1] - crd[5];
      bx1_r    <= crd[0][OW-1:0];
      by1_r    <= crd[1][OW-1:0];

      pda2_r   <= mul_s(dby1_r, dax1_r);
      pdb2_r   <= mul_s(dbx1_r, day1_r);
      pnaa2_r  <= mul_s(dbx1_r, oy1_r);
      pnab2_r  <= mul_s(dby1_r, ox1_r);
      pnba2_r  <= mul_s(dax1_r, oy1_r);
      pnbb2_r  <= mul_s(day1_r, ox1_r);
      dax2_r   <= dax1_r;
      day2_r   <= day1_r;
      bx2_r    <= bx1_r;
      by2_r    <= by1_r;

      det3_r   <= pda2_r - pdb2_r;
      na3_r    <= pnaa2_r - pnab2_r;
      nb3_r    <= pnba2_r - pnbb2_r;
      dax3_r   <= dax2_r;
      day3_r   <= day2_r;
      bx3_r    <= bx2_r;
      by3_r    <= by2_r;

      side4_r  <= side4_nxt;
      den4_r   <= det3_r[PW-1] ? neg_det[MW-1:0] : det3_r[MW-1:0];
      namag4_r <= na3_r[PW-1] ? neg_na[MW-1:0] : na3_r[MW-1:0];
      axmag4_r <= dax3_r[DW-1] ? neg_dax[AW-1:0] : dax3_r[AW-1:0];
      aymag4_r <= day3_r[DW-1] ? neg_day[AW-1:0] : day3_r[AW-1:0];

      side5_r  <= side4_r;
      den5_r   <= den4_r;
      ppxl5_r  <= mul_pp(axmag4_r, namag4_r[LW-1:0]);
      ppxh5_r  <= mul_pp(axmag4_r, {1'b0, namag4_r[MW-1:LW]});
      ppyl5_r  <= mul_pp(aymag4_r, namag4_r[LW-1:0]);
      ppyh5_r  <= mul_pp(aymag4_r, {1'b0, namag4_r[MW-1:LW]});

      side6_r  <= side5_r;
      den6_r   <= den5_r;
      numx6_r  <= {ppxh5_r[AW+HW-1:0], {LW{1'b0}}} + {{(NW-PPW){1'b0}}, ppxl5_r};
      numy6_r  <= {ppyh5_r[AW+HW-1:0], {LW{1'b0}}} + {{(NW-PPW){1'b0}}, ppyl5_r};
    end
  end

  // ---------------- stages 7..22: quotient magnitudes ----------------
  ssi_pkg::div_in_t  div_in;
  ssi_pkg::div_out_t div_out;

  assign div_in.valid = v6_r;
  assign div_in.side  = side6_r;
  assign div_in.num_x = numx6_r;
  assign div_in.num_y = numy6_r;
  assign div_in.den   = den6_r;

  ssi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .din   (div_in),
    .dout  (div_out)
  );

  // Apply the quotient sign, offset from the first segment start, zero misses.
  logic [OW-1:0] qx_s, qy_s, px, py;
  logic [31:0]   res_tdata;
  logic [2:0]    res_tuser;

  always_comb begin
    qx_s      = div_out.side.neg_x ? (~div_out.q_x + 1'b1) : div_out.q_x;
    qy_s      = div_out.side.neg_y ? (~div_out.q_y + 1'b1) : div_out.q_y;
    px        = div_out.side.base_x + qx_s;
    py        = div_out.side.base_y + qy_s;
    res_tdata = div_out.side.hit ? {py, px} : '0;
    res_tuser = {div_out.side.outcome, div_out.side.hit};
  end

  // ---------------- output register plus one skid entry ----------------
  logic        out_valid_r, skid_valid_r;
  logic [31:0] out_data_r, skid_data_r;
  logic [2:0]  out_user_r, skid_user_r;
  logic        push, pop, out_busy;

  // Advance the pipeline whenever the skid entry is free.
  assign adv      = !skid_valid_r;
  assign push     = div_out.valid && adv;
  assign pop      = out_valid_r && out_tready;
  assign out_busy = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // drain the skid entry into the output register
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_busy) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end
    end else if (push) begin
      if (out_busy) begin
        skid_data_r <= res_tdata;
        skid_user_r <= res_tuser;
      end else begin
        out_data_r <= res_tdata;
        out_user_r <= res_tuser;
      end
    end
  end

  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ hw/rtl/ssi_chk.sv @@
// Port-level checks for the segment intersection core, bound to its top level.
module ssi_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or dropped");

  // hit flag and outcome code agree
  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tuser[2:1] == ssi_pkg::OUT_HIT)))
    else $error("hit flag disagrees with outcome");

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata == '0))
    else $error("miss with nonzero crossing point");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind segment_segment_intersection_core ssi_chk u_ssi_chk (.*);
